/* rtl/skc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package skc_pkg;

    localparam int CMD_W      = 2;
    localparam int TAP_IDX_W  = 8;
    localparam int SAMPLE_W   = 24;
    localparam int WEIGHT_W   = 18;
    localparam int INDEX_W    = 21;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 1;

    // signed sample times weight with a zero sign bit
    localparam int PROD_W     = SAMPLE_W + WEIGHT_W + 1;

    localparam int ROUND_SHIFT = 18;
    localparam int ROUND_HALF  = 131072;
    localparam int SAMPLE_MAX  = 8388607;
    localparam int SAMPLE_MIN  = -8388608;
    localparam int WEIGHT_MAX  = 262143;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_OFFSET = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [WEIGHT_W-1:0]        weight_t;

    typedef struct packed {
        logic clear;   // zero the accumulator
        logic act;     // tail sample and weight address belong to the window
    } mac_ctl_t;

endpackage

`default_nettype wire

/* rtl/skc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module skc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/skc_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module skc_cell
    import skc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    shift,
    input  wire sample_t d,
    output sample_t      q
);

    sample_t sample_reg;

    // one delay-line slot; moves one place along the chain when shifting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else if (shift)
        begin
            sample_reg <= d;
        end
    end

    assign q = sample_reg;

endmodule

`default_nettype wire

/* rtl/skc_mac.sv */
`timescale 1ns / 1ps
`default_nettype none

module skc_mac
    import skc_pkg::*;
#(
    parameter int ACC_W = 52
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mac_ctl_t ctl,
    input  wire sample_t  sample,
    input  wire weight_t  weight,
    output sample_t       result
);

    sample_t                   sample_d_reg;
    logic                      act1_reg;
    logic                      act2_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   rnd;
    logic signed [ACC_W-1:0]   shifted;

    // weight arrives the cycle after its address, so the sample is held back by a register too
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act1_reg <= 1'b0;
            act2_reg <= 1'b0;
        end
        else
        begin
            act1_reg <= ctl.act;
            act2_reg <= act1_reg;
        end
    end

    assign prod_next = $signed(sample_d_reg) * $signed({1'b0, weight});

    always_ff @(posedge clk)
    begin
        sample_d_reg <= sample;
        prod_reg     <= prod_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (act2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // round half up to Q2.22, then saturate
    always_comb
    begin
        rnd     = acc_reg + ACC_W'(ROUND_HALF);
        shifted = rnd >>> ROUND_SHIFT;
        if (shifted > ACC_W'(SAMPLE_MAX))
        begin
            result = sample_t'(SAMPLE_MAX);
        end
        else if (shifted < ACC_W'(SAMPLE_MIN))
        begin
            result = sample_t'(SAMPLE_MIN);
        end
        else
        begin
            result = shifted[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/sliding_kernel_convolution.sv */
// A sample that completes a window gives its word on m_tdata after the delay line is
// rotated once through all MAX_TAPS cells and the multiply-accumulate has drained. No
// further word is taken meanwhile, a wait set by the single shared multiply-accumulate
// at the chain tail. Loads, restarts and samples that do not fill a window are taken one
// per cycle while the block is idle. rst_n is asynchronous: control state and the delay
// line clear, kernel_length reads 1, window_offset 0; weights are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module sliding_kernel_convolution
    import skc_pkg::*;
#(
    parameter int MAX_TAPS   = 256,
    parameter int MAX_POINTS = 1048576
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,   // tap_index[7:0], sample_value[31:8]
    input  wire logic [CMD_W-1:0]     s_tuser,   // command[1:0]

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [47:0]               m_tdata,   // broadened_value[23:0], output_index[44:24]

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int PW    = $clog2(MAX_POINTS);
    localparam int ACC_W = PROD_W + AW + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROT   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]          state_reg;
    logic [CFG_W-1:0]    kernel_length_reg;
    logic [CFG_W-1:0]    window_offset_reg;
    logic [CW-1:0]       filled_reg;
    logic [CW-1:0]       filled_next;
    logic [PW-1:0]       pos_reg;
    logic [PW-1:0]       pos_next;
    logic [PW-1:0]       start_reg;
    logic [AW-1:0]       r_reg;
    logic [AW-1:0]       q_reg;
    logic [AW-1:0]       rstart_reg;
    logic [CFG_W-1:0]    len_reg;
    logic                drain_reg;
    sample_t             out_value_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic                m_tvalid_reg;

    logic [CMD_W-1:0]     cmd;
    logic [TAP_IDX_W-1:0] tap;
    sample_t              val;
    logic                 accept;
    logic                 sample_acc;
    logic                 load_acc;
    logic                 restart_acc;
    logic [31:0]          len_w;
    logic                 rot;
    logic                 act;
    logic                 r_last;
    logic                 out_free;
    weight_t              wdata;
    logic                 ram_we;
    logic [31:0]          tap_wide;
    weight_t              rdata;
    sample_t              tail;
    sample_t              mac_result;
    mac_ctl_t             mac_ctl;
    logic [25:0]          idx_wide;

    sample_t cell_d [MAX_TAPS];
    sample_t cell_q [MAX_TAPS];

    assign cmd         = s_tuser;
    assign tap         = s_tdata[TAP_IDX_W-1:0];
    assign val         = s_tdata[TAP_IDX_W+SAMPLE_W-1:TAP_IDX_W];
    assign s_tready    = (state_reg == ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign sample_acc  = accept && (cmd == CMD_SAMPLE);
    assign load_acc    = accept && (cmd == CMD_LOAD);
    assign restart_acc = accept && (cmd == CMD_RESTART);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_length_reg <= CFG_W'(1);
            window_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KERNEL_LENGTH: kernel_length_reg <= cfg_data;
                REG_WINDOW_OFFSET: window_offset_reg <= cfg_data;
                default:           kernel_length_reg <= kernel_length_reg;
            endcase
        end
    end

    // taps in use: zero acts as one, clipped to the chain length
    always_comb
    begin
        if (kernel_length_reg == '0)
        begin
            len_w = 32'd1;
        end
        else if (32'(kernel_length_reg) > 32'(MAX_TAPS))
        begin
            len_w = 32'(MAX_TAPS);
        end
        else
        begin
            len_w = 32'(kernel_length_reg);
        end
    end

    assign filled_next = (32'(filled_reg) < 32'(MAX_TAPS)) ? filled_reg + CW'(1) : filled_reg;
    assign pos_next    = (32'(pos_reg) + 32'd1 >= 32'(MAX_POINTS)) ? '0 : pos_reg + PW'(1);

    // weight store
    always_comb
    begin
        if (val[SAMPLE_W-1])
        begin
            wdata = '0;
        end
        else if (val[SAMPLE_W-2:WEIGHT_W] != '0)
        begin
            wdata = weight_t'(WEIGHT_MAX);
        end
        else
        begin
            wdata = val[WEIGHT_W-1:0];
        end
    end

    assign tap_wide = 32'(tap);
    assign ram_we   = load_acc && (tap_wide < 32'(MAX_TAPS));

    skc_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAX_TAPS)
    ) u_weights (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tap_wide[AW-1:0]),
        .wdata (wdata),
        .raddr (q_reg),
        .rdata (rdata)
    );

    // delay line: a sample shifts in at the head; while rotating the tail feeds the head,
    // so after MAX_TAPS steps the line is back in order
    assign rot  = (state_reg == ST_ROT);
    assign tail = cell_q[MAX_TAPS-1];

    genvar k;
    generate
        for (k = 0; k < MAX_TAPS; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign cell_d[k] = rot ? tail : val;
            end
            else
            begin : g_body
                assign cell_d[k] = cell_q[k-1];
            end

            skc_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (sample_acc || rot),
                .d     (cell_d[k]),
                .q     (cell_q[k])
            );
        end
    endgenerate

    // the tail shows sample_line[MAX_TAPS-1-r]; the window starts at r = MAX_TAPS - len
    assign act    = rot && (r_reg >= rstart_reg);
    assign r_last = (32'(r_reg) == 32'(MAX_TAPS) - 32'd1);

    assign mac_ctl.clear = sample_acc;
    assign mac_ctl.act   = act;

    skc_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .sample (tail),
        .weight (rdata),
        .result (mac_result)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign idx_wide = 26'(start_reg) - 26'($signed(window_offset_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            filled_reg   <= '0;
            pos_reg      <= '0;
            start_reg    <= '0;
            r_reg        <= '0;
            q_reg        <= '0;
            rstart_reg   <= '0;
            len_reg      <= '0;
            drain_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (restart_acc)
                    begin
                        filled_reg <= '0;
                        pos_reg    <= '0;
                    end
                    else if (sample_acc)
                    begin
                        filled_reg <= filled_next;
                        pos_reg    <= pos_next;
                        start_reg  <= pos_reg;
                        len_reg    <= len_w[CFG_W-1:0];
                        rstart_reg <= AW'(32'(MAX_TAPS) - len_w);
                        r_reg      <= '0;
                        q_reg      <= '0;
                        if (32'(filled_next) >= len_w)
                        begin
                            state_reg <= ST_ROT;
                        end
                    end
                end
                ST_ROT:
                begin
                    r_reg <= r_reg + AW'(1);
                    if (act)
                    begin
                        q_reg <= q_reg + AW'(1);
                        // step back to the window start, one point per tap after the first
                        if (q_reg != '0)
                        begin
                            start_reg <= (start_reg == '0) ? PW'(MAX_POINTS - 1)
                                                           : start_reg - PW'(1);
                        end
                    end
                    if (r_last)
                    begin
                        drain_reg <= 1'b0;
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    drain_reg <= 1'b1;
                    if (drain_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_value_reg <= mac_result;
            out_index_reg <= idx_wide[INDEX_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_index_reg, out_value_reg};

    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(filled_reg) <= 32'(MAX_TAPS))
        else $error("fill count above chain length");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < 32'(MAX_POINTS))
        else $error("sample position out of range");

    a_taps_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROT && r_last) |-> (32'(q_reg) == 32'(len_reg) - 32'd1))
        else $error("rotation ended with wrong number of taps read");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside finish step");

endmodule

`default_nettype wire

/* sim/sliding_kernel_convolution_test.sv */
`timescale 1ns / 1ps

module sliding_kernel_convolution_test;
    import skc_pkg::*;

    localparam int MAX_TAPS   = 256;
    localparam int MAX_POINTS = 1048576;
    localparam int LONG_HOLD  = 2000;
    localparam int DRAIN_WAIT = MAX_TAPS + 8;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [INDEX_W-1:0]  index;
    } conv_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;   // tap_index[7:0], sample_value[31:8]
    logic [CMD_W-1:0]     s_tuser   = '0;   // command[1:0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [47:0]          m_tdata;          // broadened_value[23:0], output_index[44:24]
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // predictor copy of the block state
    weight_t          tap_weight [MAX_TAPS];
    sample_t          delay_line [MAX_TAPS];
    int               fill_count;
    int               next_position;
    logic [CFG_W-1:0] kernel_len_cfg;
    logic [CFG_W-1:0] window_off_cfg;

    conv_result_t pending_results [$];
    conv_result_t oldest;
    int           error_count  = 0;
    bit           idle_on      = 1'b1;
    bit           hold_request = 1'b0;

    sliding_kernel_convolution #(
        .MAX_TAPS   (MAX_TAPS),
        .MAX_POINTS (MAX_POINTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int taps_in_use();
        int n;
        n = int'(kernel_len_cfg);
        if (n == 0) n = 1;
        if (n > MAX_TAPS) n = MAX_TAPS;
        return n;
    endfunction

    function automatic void convolve_word(logic [CMD_W-1:0] cmd, logic [TAP_IDX_W-1:0] tap,
                                          sample_t val);
        int           len;
        int           back;
        int           start;
        int           cur;
        int           offset_val;
        longint       acc;
        longint       rounded;
        conv_result_t res;
        case (cmd)
            CMD_LOAD:
            begin
                if (val < 0) tap_weight[tap] = '0;
                else if (val > WEIGHT_MAX) tap_weight[tap] = weight_t'(WEIGHT_MAX);
                else tap_weight[tap] = weight_t'(val);
            end
            CMD_RESTART:
            begin
                fill_count    = 0;
                next_position = 0;
            end
            CMD_SAMPLE:
            begin
                for (int i = MAX_TAPS - 1; i > 0; i--)
                    delay_line[i] = delay_line[i - 1];
                delay_line[0] = val;
                if (fill_count < MAX_TAPS) fill_count++;
                cur = next_position;
                next_position = (cur + 1 >= MAX_POINTS) ? 0 : cur + 1;
                len = taps_in_use();
                if (fill_count >= len)
                begin
                    // tap 0 meets the oldest sample of the window
                    acc = 0;
                    for (int q = 0; q < len; q++)
                        acc += longint'(delay_line[len - 1 - q]) * longint'(tap_weight[q]);
                    rounded = (acc + ROUND_HALF) >>> ROUND_SHIFT;
                    if (rounded > SAMPLE_MAX) rounded = SAMPLE_MAX;
                    if (rounded < SAMPLE_MIN) rounded = SAMPLE_MIN;
                    back = len - 1;
                    start = (cur >= back) ? cur - back : cur + MAX_POINTS - back;
                    offset_val = int'($signed(window_off_cfg));
                    res.value = rounded[SAMPLE_W-1:0];
                    res.index = INDEX_W'(start - offset_val);
                    pending_results = {pending_results, res};
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0: return sample_t'(SAMPLE_MAX);
            1: return sample_t'(SAMPLE_MIN);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic sample_t weight_value();
        case ($urandom_range(0, 9))
            0: return sample_t'($urandom);    // mostly clamped
            1: return sample_t'(WEIGHT_MAX);
            2: return '0;
            default: return sample_t'($urandom_range(0, 4095));
        endcase
    endfunction

    // entered and left at a rising edge; valid stays high into the next word
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [TAP_IDX_W-1:0] tap, sample_t val);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {val, tap};
        do
            @(posedge clk);
        while (!s_tready);
        convolve_word(cmd, tap, val);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic pause_until_drained();
        stop_sending();
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // loads queued behind the last result may still be in flight
    task automatic settle_block();
        pause_until_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_KERNEL_LENGTH) kernel_len_cfg = data;
        else window_off_cfg = data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [CFG_W-1:0] len, logic [CFG_W-1:0] off);
        settle_block();
        write_reg(REG_KERNEL_LENGTH, len);
        write_reg(REG_WINDOW_OFFSET, off);
    endtask

    task automatic load_kernel();
        sample_t w;
        for (int t = 0; t < MAX_TAPS; t++)
        begin
            case (t)
                1: w = sample_t'(-1);
                2: w = sample_t'(SAMPLE_MAX);
                3: w = sample_t'(WEIGHT_MAX);
                4: w = sample_t'(WEIGHT_MAX + 1);
                5: w = sample_t'(SAMPLE_MIN);
                default: w = sample_t'($urandom_range(0, 2047));
            endcase
            send_word(CMD_LOAD, t[TAP_IDX_W-1:0], w);
        end
    endtask

    // reset settings: one tap, zero offset
    task automatic test_single_tap();
        send_word(CMD_SAMPLE, '0, sample_t'(SAMPLE_MAX));
        send_word(CMD_SAMPLE, 8'hFF, sample_t'(SAMPLE_MIN));
        send_word(CMD_SAMPLE, '0, '0);
        send_word(CMD_SAMPLE, '0, sample_t'(-1));
        send_word(CMD_UNUSED, 8'hA5, random_sample());
        send_word(CMD_RESTART, '0, '0);
        send_word(CMD_SAMPLE, '0, sample_t'(1));
        send_word(CMD_SAMPLE, '0, random_sample());
    endtask

    // weight of one half: odd samples land exactly on the rounding midpoint
    task automatic test_rounding();
        send_word(CMD_LOAD, '0, sample_t'(ROUND_HALF));
        send_word(CMD_SAMPLE, '0, sample_t'(1));
        send_word(CMD_SAMPLE, '0, sample_t'(-1));
        send_word(CMD_SAMPLE, '0, sample_t'(3));
        send_word(CMD_SAMPLE, '0, sample_t'(-3));
        send_word(CMD_SAMPLE, '0, sample_t'(SAMPLE_MIN));
        send_word(CMD_LOAD, '0, weight_value());
    endtask

    task automatic test_saturation();
        set_config(9'd4, '0);
        for (int t = 0; t < 4; t++)
            send_word(CMD_LOAD, t[TAP_IDX_W-1:0], sample_t'(WEIGHT_MAX));
        send_word(CMD_RESTART, '0, '0);
        repeat (4) send_word(CMD_SAMPLE, '0, sample_t'(SAMPLE_MAX));
        repeat (4) send_word(CMD_SAMPLE, '0, sample_t'(SAMPLE_MIN));
        for (int t = 0; t < 4; t++)
            send_word(CMD_LOAD, t[TAP_IDX_W-1:0], sample_t'($urandom_range(0, 2047)));
    endtask

    task automatic test_backpressure();
        set_config(9'd3, 9'h1F9);
        hold_request = 1'b1;
        repeat (40) send_word(CMD_SAMPLE, TAP_IDX_W'($urandom_range(0, 255)), random_sample());
        pause_until_drained();
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0] len_list [9];
        logic [CFG_W-1:0] off_list [9];
        int               items;
        int               pick;
        len_list = '{9'd1, 9'd0, 9'd2, 9'd256, 9'd511, 9'd300, 9'd1, 9'd1, 9'd1};
        off_list = '{9'h0FF, 9'h100, 9'h001, 9'h000, 9'h1FF, 9'h0F0, 9'h0, 9'h0, 9'h0};
        for (int p = 0; p < 9; p++)
        begin
            if (p >= 6)
            begin
                len_list[p] = CFG_W'($urandom_range(1, 16));
                off_list[p] = CFG_W'($urandom_range(0, 511));
            end
            idle_on = (p != 3) && (p != 8);
            set_config(len_list[p], off_list[p]);
            // the clipped-length phases keep the full window of the phase before
            if (p != 4 && p != 5)
                send_word(CMD_RESTART, TAP_IDX_W'($urandom_range(0, 255)), random_sample());
            items = (p == 3) ? 320 : 30;
            for (int n = 0; n < items; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3 && taps_in_use() <= 32)
                    send_word(CMD_RESTART, TAP_IDX_W'($urandom_range(0, 255)),
                              random_sample());
                else if (pick < 10)
                    send_word(CMD_LOAD, TAP_IDX_W'($urandom_range(0, 255)), weight_value());
                else if (pick < 13)
                    send_word(CMD_UNUSED, TAP_IDX_W'($urandom_range(0, 255)),
                              random_sample());
                else if (pick == 13)
                    pause_until_drained();
                else
                    send_word(CMD_SAMPLE, TAP_IDX_W'($urandom_range(0, 255)),
                              random_sample());
            end
        end
    endtask

    // result side: random stalls, plus one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20) - 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: word with none expected: value %h index %h", $time,
                         m_tdata[SAMPLE_W-1:0], m_tdata[SAMPLE_W+INDEX_W-1:SAMPLE_W]);
                error_count++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (m_tdata[SAMPLE_W-1:0] !== oldest.value)
                begin
                    $display("%0t: broadened_value expected %h got %h", $time,
                             oldest.value, m_tdata[SAMPLE_W-1:0]);
                    error_count++;
                end
                if (m_tdata[SAMPLE_W+INDEX_W-1:SAMPLE_W] !== oldest.index)
                begin
                    $display("%0t: output_index expected %h got %h", $time,
                             oldest.index, m_tdata[SAMPLE_W+INDEX_W-1:SAMPLE_W]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #15_000_000;
        $display("[sliding_kernel_convolution] ERROR");
        $finish;
    end

    initial
    begin
        kernel_len_cfg = 9'd1;
        window_off_cfg = '0;
        fill_count     = 0;
        next_position  = 0;
        foreach (delay_line[i]) delay_line[i] = '0;
        foreach (tap_weight[i]) tap_weight[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_kernel();
        test_single_tap();
        test_rounding();
        test_saturation();
        test_backpressure();
        test_random_phases();
        pause_until_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("[sliding_kernel_convolution] OK");
        else
            $display("[sliding_kernel_convolution] ERROR");
        $finish;
    end

endmodule
